[hdl/arc_chord_interpolator_unit_macros.svh]
// Assertion macros shared by the arc chord interpolator modules.
`ifndef ARC_CHORD_INTERPOLATOR_UNIT_MACROS_SVH
`define ARC_CHORD_INTERPOLATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ACI_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ACI_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/aci_pkg.sv]
// Shared types, constants and tables of the arc chord interpolator.
package aci_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int CORDIC_ITERS    = 20;
    localparam int MAX_SEGMENTS    = 63;
    localparam int SQRT_ITERS      = 32;
    localparam int CNT_W           = 5;

    localparam int IN_TDATA_W  = 208;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 96;
    localparam int OUT_TUSER_W = 1;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam int DIV_W     = 33;
    localparam int DVS_W     = 30;
    localparam int DIV_CNT_W = 6;
    localparam int VEC_W     = 38;
    localparam int Z_W       = 34;

    localparam logic [63:0] ZERO_SQ_MAX =
        ((64'd1 << (2 * COORD_FRAC_BITS)) - 64'd1) / 64'd1000000;
    localparam logic [31:0] HALF_TURN       = 32'h8000_0000;
    localparam logic [31:0] QUARTER_TURN    = 32'h4000_0000;
    localparam logic [31:0] NEAR_ZERO_SWEEP = 32'd68357;
    localparam logic [31:0] CORDIC_KINV     = 32'd2608131496;
    localparam logic [32:0] DLY_NUMER       = 33'd60000000;
    localparam logic [10:0] MIN_DLY_PAD     = 11'd50;

    typedef enum logic [1:0] {
        CFG_ARC_STEP   = 2'd0,
        CFG_STEPS_MM   = 2'd1,
        CFG_DEF_DELAY  = 2'd2,
        CFG_PULSE_HIGH = 2'd3
    } t_cfg_idx;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQ_I,
        OP_SQ_J,
        OP_ERR_EMIT,
        OP_SQRT_STEP,
        OP_MUL_FS,
        OP_DLY_GO,
        OP_DLY_SET,
        OP_MUL_RK,
        OP_VEC_S,
        OP_VEC_E,
        OP_VEC_STEP,
        OP_MAG,
        OP_SEG_GO,
        OP_SEG_SET,
        OP_ANG_GO,
        OP_ANG_SET,
        OP_ACC,
        OP_ROT_INIT,
        OP_ROT_STEP,
        OP_EMIT_PT,
        OP_EMIT_END
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [CNT_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic zero_rad;
        logic feed_zero;
        logic div_busy;
        logic out_free;
        logic seg_last;
    } t_sts;

    function automatic logic [31:0] atan_lut(input logic [CNT_W-1:0] k);
        logic [31:0] v;
        case (k)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933405;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10680862;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335086;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41721;
            5'd15:   v = 32'd20860;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2607;
            5'd19:   v = 32'd1303;
            5'd20:   v = 32'd651;
            5'd21:   v = 32'd325;
            5'd22:   v = 32'd162;
            5'd23:   v = 32'd81;
            5'd24:   v = 32'd40;
            5'd25:   v = 32'd20;
            5'd26:   v = 32'd10;
            5'd27:   v = 32'd5;
            5'd28:   v = 32'd2;
            5'd29:   v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

[hdl/aci_div.sv]
// Restoring divider, one quotient bit per cycle.
module aci_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [aci_pkg::DIV_W-1:0]   i_dividend,
    input  logic [aci_pkg::DVS_W-1:0]   i_divisor,
    output logic                        o_busy,
    output logic [aci_pkg::DIV_W-1:0]   o_quotient,
    output logic [aci_pkg::DVS_W-1:0]   o_remainder
);

    logic                            r_busy;
    logic [aci_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [aci_pkg::DIV_W-1:0]       r_quo;
    logic [aci_pkg::DVS_W-1:0]       r_rem;
    logic [aci_pkg::DVS_W-1:0]       r_dvs;
    logic [aci_pkg::DVS_W:0]         w_sh;
    logic [aci_pkg::DVS_W:0]         w_diff;
    logic                            w_ge;

    assign w_sh   = {r_rem, r_quo[aci_pkg::DIV_W-1]};
    assign w_diff = w_sh - {1'b0, r_dvs};
    assign w_ge   = (w_sh >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= aci_pkg::DIV_CNT_W'(aci_pkg::DIV_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == aci_pkg::DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[aci_pkg::DVS_W-1:0] : w_sh[aci_pkg::DVS_W-1:0];
            r_quo <= {r_quo[aci_pkg::DIV_W-2:0], w_ge};
        end
    end

    assign o_busy      = r_busy;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

[hdl/aci_dpath.sv]
// Datapath: config registers, multiplier, divider, square root, CORDIC, chord stepping, output register.
`include "arc_chord_interpolator_unit_macros.svh"
module aci_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  aci_pkg::t_cmd                       i_cmd,
    output aci_pkg::t_sts                       o_sts,
    input  logic [aci_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    input  logic [aci_pkg::IN_TUSER_W-1:0]      i_s_tuser,
    input  logic                                i_cfg_wr_en,
    input  logic [aci_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [aci_pkg::CFG_DATA_W-1:0]      i_cfg_wr_data,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [aci_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    output logic [aci_pkg::OUT_TUSER_W-1:0]     o_m_tuser,
    output logic                                o_m_tlast
);

    localparam int VW = aci_pkg::VEC_W;
    localparam int ZW = aci_pkg::Z_W;

    // config
    logic [6:0]  r_cfg_deg;
    logic [13:0] r_cfg_spm;
    logic [15:0] r_cfg_ddly;
    logic [9:0]  r_cfg_pulse;

    // command fields
    logic        r_ccw;
    logic [31:0] r_sx, r_sy, r_ex, r_ey, r_oi, r_oj;
    logic [15:0] r_feed;
    logic [32:0] r_cx, r_cy;

    // arithmetic state
    logic [63:0]           r_sv, r_res;
    logic [29:0]           r_fs;
    logic [25:0]           r_dly;
    logic [31:0]           r_x0;
    logic signed [VW-1:0]  r_vx, r_vy;
    logic signed [ZW-1:0]  r_z;
    logic [31:0]           r_ang, r_as, r_rot_ang;
    logic                  r_zero;
    logic [32:0]           r_mag, r_qstep, r_dacc;
    logic [5:0]            r_segs, r_rstep, r_racc, r_k;

    // output register
    logic        r_out_valid;
    logic [31:0] r_out_px, r_out_py;
    logic [25:0] r_out_dly;
    logic [5:0]  r_out_segs;
    logic        r_out_st, r_out_last;

    // combinational
    logic [31:0]          w_in_sx, w_in_sy, w_in_ex, w_in_ey, w_in_oi, w_in_oj;
    logic [15:0]          w_in_feed;
    logic signed [32:0]   w_ma, w_mb;
    logic signed [65:0]   w_mp;
    logic [13:0]          w_spm;
    logic [6:0]           w_deg;
    logic [63:0]          w_bit, w_trial;
    logic [VW-1:0]        w_vx, w_vy;
    logic signed [VW-1:0] w_dx, w_dy;
    logic [ZW-1:0]        w_atan;
    logic [31:0]          w_ang_fin, w_sweep;
    logic [41:0]          w_mag360;
    logic [6:0]           w_sumr;
    logic                 w_carry;
    logic [32:0]          w_dacc_n;
    logic                 w_fold;
    logic [31:0]          w_rot_a;
    logic [10:0]          w_min_dly;
    logic                 w_div_start;
    logic [aci_pkg::DIV_W-1:0] w_div_a, w_div_q;
    logic [aci_pkg::DVS_W-1:0] w_div_b, w_div_r;
    logic                 w_div_busy;
    logic                 w_out_free;
    logic                 w_emit;

    function automatic logic [31:0] sat32(input logic [38:0] v);
        logic [31:0] s;
        if (!v[38] && (v[37:31] != 7'd0)) begin
            s = 32'h7FFF_FFFF;
        end else if (v[38] && (v[37:31] != 7'h7F)) begin
            s = 32'h8000_0000;
        end else begin
            s = v[31:0];
        end
        return s;
    endfunction

    assign w_in_sx   = i_s_tdata[31:0];
    assign w_in_sy   = i_s_tdata[63:32];
    assign w_in_ex   = i_s_tdata[95:64];
    assign w_in_ey   = i_s_tdata[127:96];
    assign w_in_oi   = i_s_tdata[159:128];
    assign w_in_oj   = i_s_tdata[191:160];
    assign w_in_feed = i_s_tdata[207:192];

    assign w_spm = (r_cfg_spm == 14'd0) ? 14'd1 : r_cfg_spm;
    assign w_deg = (r_cfg_deg == 7'd0) ? 7'd1 : r_cfg_deg;

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (i_cmd.op)
            aci_pkg::OP_SQ_I: begin
                w_ma = {r_oi[31], r_oi};
                w_mb = {r_oi[31], r_oi};
            end
            aci_pkg::OP_SQ_J: begin
                w_ma = {r_oj[31], r_oj};
                w_mb = {r_oj[31], r_oj};
            end
            aci_pkg::OP_MUL_FS: begin
                w_ma = {17'd0, r_feed};
                w_mb = {19'd0, w_spm};
            end
            aci_pkg::OP_MUL_RK: begin
                w_ma = {1'b0, r_res[31:0]};
                w_mb = {1'b0, aci_pkg::CORDIC_KINV};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end
    assign w_mp = w_ma * w_mb;

    assign w_bit   = 64'd1 << (6'd62 - {i_cmd.idx, 1'b0});
    assign w_trial = r_res + w_bit;

    assign w_vx = (i_cmd.op == aci_pkg::OP_VEC_S) ? (VW'(0) - {{6{r_oi[31]}}, r_oi}) :
                  ({{6{r_ex[31]}}, r_ex} - {{5{r_cx[32]}}, r_cx});
    assign w_vy = (i_cmd.op == aci_pkg::OP_VEC_S) ? (VW'(0) - {{6{r_oj[31]}}, r_oj}) :
                  ({{6{r_ey[31]}}, r_ey} - {{5{r_cy[32]}}, r_cy});

    assign w_dx   = r_vy >>> i_cmd.idx;
    assign w_dy   = r_vx >>> i_cmd.idx;
    assign w_atan = {2'b00, aci_pkg::atan_lut(i_cmd.idx)};

    assign w_ang_fin = r_zero ? 32'd0 : r_ang;
    assign w_sweep   = r_ccw ? (w_ang_fin - r_as) : (r_as - w_ang_fin);
    assign w_mag360  = {9'd0, r_mag} * 42'd360;

    assign w_sumr   = {1'b0, r_racc} + {1'b0, r_rstep};
    assign w_carry  = (w_sumr >= {1'b0, r_segs});
    assign w_dacc_n = r_dacc + r_qstep + {32'd0, w_carry};

    assign w_fold  = r_rot_ang[31] ^ r_rot_ang[30];
    assign w_rot_a = w_fold ? (r_rot_ang - aci_pkg::HALF_TURN) : r_rot_ang;

    assign w_min_dly = {1'b0, r_cfg_pulse} + aci_pkg::MIN_DLY_PAD;

    always_comb begin
        w_div_start = 1'b0;
        w_div_a     = '0;
        w_div_b     = '0;
        case (i_cmd.op)
            aci_pkg::OP_DLY_GO: begin
                w_div_start = (r_feed != 16'd0);
                w_div_a     = aci_pkg::DLY_NUMER;
                w_div_b     = r_fs;
            end
            aci_pkg::OP_SEG_GO: begin
                w_div_start = 1'b1;
                w_div_a     = {24'd0, w_mag360[40:32]};
                w_div_b     = {23'd0, w_deg};
            end
            aci_pkg::OP_ANG_GO: begin
                w_div_start = 1'b1;
                w_div_a     = r_mag;
                w_div_b     = {24'd0, r_segs};
            end
            default: begin
                w_div_start = 1'b0;
            end
        endcase
    end

    aci_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_div_a),
        .i_divisor   (w_div_b),
        .o_busy      (w_div_busy),
        .o_quotient  (w_div_q),
        .o_remainder (w_div_r)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_deg   <= 7'd6;
            r_cfg_spm   <= 14'd200;
            r_cfg_ddly  <= 16'd1000;
            r_cfg_pulse <= 10'd10;
        end else if (i_cfg_wr_en) begin
            case (aci_pkg::t_cfg_idx'(i_cfg_index))
                aci_pkg::CFG_ARC_STEP:   r_cfg_deg   <= i_cfg_wr_data[6:0];
                aci_pkg::CFG_STEPS_MM:   r_cfg_spm   <= i_cfg_wr_data[13:0];
                aci_pkg::CFG_DEF_DELAY:  r_cfg_ddly  <= i_cfg_wr_data;
                aci_pkg::CFG_PULSE_HIGH: r_cfg_pulse <= i_cfg_wr_data[9:0];
                default:                 r_cfg_deg   <= r_cfg_deg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            aci_pkg::OP_LOAD: begin
                r_ccw  <= i_s_tuser[0];
                r_sx   <= w_in_sx;
                r_sy   <= w_in_sy;
                r_ex   <= i_s_tuser[1] ? w_in_ex : w_in_sx;
                r_ey   <= i_s_tuser[2] ? w_in_ey : w_in_sy;
                r_oi   <= w_in_oi;
                r_oj   <= w_in_oj;
                r_feed <= w_in_feed;
                r_cx   <= {w_in_sx[31], w_in_sx} + {w_in_oi[31], w_in_oi};
                r_cy   <= {w_in_sy[31], w_in_sy} + {w_in_oj[31], w_in_oj};
            end
            aci_pkg::OP_SQ_I: begin
                r_sv <= w_mp[63:0];
            end
            aci_pkg::OP_SQ_J: begin
                r_sv  <= r_sv + w_mp[63:0];
                r_res <= '0;
            end
            aci_pkg::OP_SQRT_STEP: begin
                if (r_sv >= w_trial) begin
                    r_sv  <= r_sv - w_trial;
                    r_res <= (r_res >> 1) + w_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
            end
            aci_pkg::OP_MUL_FS: begin
                r_fs <= w_mp[29:0];
            end
            aci_pkg::OP_DLY_GO: begin
                r_dly <= {10'd0, r_cfg_ddly};
            end
            aci_pkg::OP_DLY_SET: begin
                r_dly <= (w_div_q < {22'd0, w_min_dly}) ? {15'd0, w_min_dly} :
                         w_div_q[25:0];
            end
            aci_pkg::OP_MUL_RK: begin
                r_x0 <= w_mp[63:32];
            end
            aci_pkg::OP_VEC_S, aci_pkg::OP_VEC_E: begin
                if (i_cmd.op == aci_pkg::OP_VEC_E) begin
                    r_as <= w_ang_fin;
                end
                r_zero <= (w_vx == '0) && (w_vy == '0);
                if (w_vx[VW-1]) begin
                    r_vx  <= VW'(0) - w_vx;
                    r_vy  <= VW'(0) - w_vy;
                    r_ang <= aci_pkg::HALF_TURN;
                end else begin
                    r_vx  <= w_vx;
                    r_vy  <= w_vy;
                    r_ang <= '0;
                end
            end
            aci_pkg::OP_VEC_STEP: begin
                if (!r_vy[VW-1] && (r_vy != '0)) begin
                    r_vx  <= r_vx + w_dx;
                    r_vy  <= r_vy - w_dy;
                    r_ang <= r_ang + w_atan[31:0];
                end else begin
                    r_vx  <= r_vx - w_dx;
                    r_vy  <= r_vy + w_dy;
                    r_ang <= r_ang - w_atan[31:0];
                end
            end
            aci_pkg::OP_MAG: begin
                r_mag <= (w_sweep < aci_pkg::NEAR_ZERO_SWEEP) ? {1'b1, 32'd0} :
                         {1'b0, w_sweep};
            end
            aci_pkg::OP_SEG_SET: begin
                if (w_div_q == '0) begin
                    r_segs <= 6'd1;
                end else if (w_div_q > aci_pkg::DIV_W'(aci_pkg::MAX_SEGMENTS)) begin
                    r_segs <= 6'(aci_pkg::MAX_SEGMENTS);
                end else begin
                    r_segs <= w_div_q[5:0];
                end
            end
            aci_pkg::OP_ANG_SET: begin
                r_qstep <= w_div_q;
                r_rstep <= w_div_r[5:0];
                r_dacc  <= '0;
                r_racc  <= '0;
                r_k     <= '0;
            end
            aci_pkg::OP_ACC: begin
                r_k       <= r_k + 6'd1;
                r_dacc    <= w_dacc_n;
                r_racc    <= w_carry ? 6'(w_sumr - {1'b0, r_segs}) : w_sumr[5:0];
                r_rot_ang <= r_ccw ? (r_as + w_dacc_n[31:0]) : (r_as - w_dacc_n[31:0]);
            end
            aci_pkg::OP_ROT_INIT: begin
                r_vx <= w_fold ? (VW'(0) - {6'd0, r_x0}) : {6'd0, r_x0};
                r_vy <= '0;
                r_z  <= {{2{w_rot_a[31]}}, w_rot_a};
            end
            aci_pkg::OP_ROT_STEP: begin
                if (!r_z[ZW-1]) begin
                    r_vx <= r_vx - w_dx;
                    r_vy <= r_vy + w_dy;
                    r_z  <= r_z - w_atan;
                end else begin
                    r_vx <= r_vx + w_dx;
                    r_vy <= r_vy - w_dy;
                    r_z  <= r_z + w_atan;
                end
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_emit = (i_cmd.op == aci_pkg::OP_EMIT_PT) || (i_cmd.op == aci_pkg::OP_EMIT_END) ||
                    (i_cmd.op == aci_pkg::OP_ERR_EMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            aci_pkg::OP_ERR_EMIT: begin
                r_out_px   <= r_sx;
                r_out_py   <= r_sy;
                r_out_dly  <= '0;
                r_out_segs <= '0;
                r_out_st   <= 1'b1;
                r_out_last <= 1'b1;
            end
            aci_pkg::OP_EMIT_PT: begin
                r_out_px   <= sat32({{6{r_cx[32]}}, r_cx} + {r_vx[VW-1], r_vx});
                r_out_py   <= sat32({{6{r_cy[32]}}, r_cy} + {r_vy[VW-1], r_vy});
                r_out_dly  <= r_dly;
                r_out_segs <= r_segs;
                r_out_st   <= 1'b0;
                r_out_last <= 1'b0;
            end
            aci_pkg::OP_EMIT_END: begin
                r_out_px   <= r_ex;
                r_out_py   <= r_ey;
                r_out_dly  <= r_dly;
                r_out_segs <= r_segs;
                r_out_st   <= 1'b0;
                r_out_last <= 1'b1;
            end
            default: begin
                r_out_st <= r_out_st;
            end
        endcase
    end

    assign o_sts.zero_rad  = (r_sv <= aci_pkg::ZERO_SQ_MAX);
    assign o_sts.feed_zero = (r_feed == 16'd0);
    assign o_sts.div_busy  = w_div_busy;
    assign o_sts.out_free  = w_out_free;
    assign o_sts.seg_last  = (r_k == r_segs);

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_segs, r_out_dly, r_out_py, r_out_px};
    assign o_m_tuser  = r_out_st;
    assign o_m_tlast  = r_out_last;

    `ACI_ASSERT_IMPL(a_err_is_last, i_clk, i_rst_n, r_out_valid && r_out_st, r_out_last && (r_out_segs == 6'd0), "error request must be single and last")
    `ACI_ASSERT_IMPL(a_acc_in_range, i_clk, i_rst_n, i_cmd.op == aci_pkg::OP_ACC, r_k < r_segs, "chord index ran past segment count")

endmodule

[hdl/aci_ctrl.sv]
// Controller: sequences one arc command through the datapath.
`include "arc_chord_interpolator_unit_macros.svh"
module aci_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  aci_pkg::t_sts i_sts,
    output aci_pkg::t_cmd o_cmd
);

    typedef enum logic [23:0] {
        S_IDLE     = 24'h000001,
        S_SQ_I     = 24'h000002,
        S_SQ_J     = 24'h000004,
        S_CHK      = 24'h000008,
        S_ERR      = 24'h000010,
        S_SQRT     = 24'h000020,
        S_MUL_FS   = 24'h000040,
        S_DLY_GO   = 24'h000080,
        S_DLY_WAIT = 24'h000100,
        S_MUL_RK   = 24'h000200,
        S_VS_INIT  = 24'h000400,
        S_VS       = 24'h000800,
        S_VE_INIT  = 24'h001000,
        S_VE       = 24'h002000,
        S_MAG      = 24'h004000,
        S_SEG_GO   = 24'h008000,
        S_SEG_WAIT = 24'h010000,
        S_ANG_GO   = 24'h020000,
        S_ANG_WAIT = 24'h040000,
        S_ACC      = 24'h080000,
        S_ROT_INIT = 24'h100000,
        S_ROT      = 24'h200000,
        S_EMIT     = 24'h400000,
        S_FINAL    = 24'h800000
    } t_state;

    t_state                       r_state, n_state;
    logic [aci_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic                         w_cordic_end;
    logic                         w_sqrt_end;

    assign w_cordic_end = (r_cnt == aci_pkg::CNT_W'(aci_pkg::CORDIC_ITERS - 1));
    assign w_sqrt_end   = (r_cnt == aci_pkg::CNT_W'(aci_pkg::SQRT_ITERS - 1));

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd.op   = aci_pkg::OP_NONE;
        o_cmd.idx  = r_cnt;
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.op = aci_pkg::OP_LOAD;
                    n_state  = S_SQ_I;
                end
            end
            S_SQ_I: begin
                o_cmd.op = aci_pkg::OP_SQ_I;
                n_state  = S_SQ_J;
            end
            S_SQ_J: begin
                o_cmd.op = aci_pkg::OP_SQ_J;
                n_state  = S_CHK;
            end
            S_CHK: begin
                n_cnt   = '0;
                n_state = i_sts.zero_rad ? S_ERR : S_SQRT;
            end
            S_ERR: begin
                if (i_sts.out_free) begin
                    o_cmd.op = aci_pkg::OP_ERR_EMIT;
                    n_state  = S_IDLE;
                end
            end
            S_SQRT: begin
                o_cmd.op = aci_pkg::OP_SQRT_STEP;
                n_cnt    = r_cnt + 1'b1;
                if (w_sqrt_end) begin
                    n_state = S_MUL_FS;
                end
            end
            S_MUL_FS: begin
                o_cmd.op = aci_pkg::OP_MUL_FS;
                n_state  = S_DLY_GO;
            end
            S_DLY_GO: begin
                o_cmd.op = aci_pkg::OP_DLY_GO;
                n_state  = i_sts.feed_zero ? S_MUL_RK : S_DLY_WAIT;
            end
            S_DLY_WAIT: begin
                if (!i_sts.div_busy) begin
                    o_cmd.op = aci_pkg::OP_DLY_SET;
                    n_state  = S_MUL_RK;
                end
            end
            S_MUL_RK: begin
                o_cmd.op = aci_pkg::OP_MUL_RK;
                n_state  = S_VS_INIT;
            end
            S_VS_INIT: begin
                o_cmd.op = aci_pkg::OP_VEC_S;
                n_cnt    = '0;
                n_state  = S_VS;
            end
            S_VS: begin
                o_cmd.op = aci_pkg::OP_VEC_STEP;
                n_cnt    = r_cnt + 1'b1;
                if (w_cordic_end) begin
                    n_state = S_VE_INIT;
                end
            end
            S_VE_INIT: begin
                o_cmd.op = aci_pkg::OP_VEC_E;
                n_cnt    = '0;
                n_state  = S_VE;
            end
            S_VE: begin
                o_cmd.op = aci_pkg::OP_VEC_STEP;
                n_cnt    = r_cnt + 1'b1;
                if (w_cordic_end) begin
                    n_state = S_MAG;
                end
            end
            S_MAG: begin
                o_cmd.op = aci_pkg::OP_MAG;
                n_state  = S_SEG_GO;
            end
            S_SEG_GO: begin
                o_cmd.op = aci_pkg::OP_SEG_GO;
                n_state  = S_SEG_WAIT;
            end
            S_SEG_WAIT: begin
                if (!i_sts.div_busy) begin
                    o_cmd.op = aci_pkg::OP_SEG_SET;
                    n_state  = S_ANG_GO;
                end
            end
            S_ANG_GO: begin
                o_cmd.op = aci_pkg::OP_ANG_GO;
                n_state  = S_ANG_WAIT;
            end
            S_ANG_WAIT: begin
                if (!i_sts.div_busy) begin
                    o_cmd.op = aci_pkg::OP_ANG_SET;
                    n_state  = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.op = aci_pkg::OP_ACC;
                n_state  = S_ROT_INIT;
            end
            S_ROT_INIT: begin
                o_cmd.op = aci_pkg::OP_ROT_INIT;
                n_cnt    = '0;
                n_state  = S_ROT;
            end
            S_ROT: begin
                o_cmd.op = aci_pkg::OP_ROT_STEP;
                n_cnt    = r_cnt + 1'b1;
                if (w_cordic_end) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.op = aci_pkg::OP_EMIT_PT;
                    n_state  = i_sts.seg_last ? S_FINAL : S_ACC;
                end
            end
            S_FINAL: begin
                if (i_sts.out_free) begin
                    o_cmd.op = aci_pkg::OP_EMIT_END;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    `ACI_ASSERT_IMPL(a_emit_free, i_clk, i_rst_n, (o_cmd.op == aci_pkg::OP_EMIT_PT) || (o_cmd.op == aci_pkg::OP_EMIT_END) || (o_cmd.op == aci_pkg::OP_ERR_EMIT), i_sts.out_free, "request written into a full output register")
    `ACI_ASSERT_IMPL(a_idle_div, i_clk, i_rst_n, r_state == S_IDLE, !i_sts.div_busy, "divider still running while idle")
    `ACI_ASSERT_NEXT(a_load_next, i_clk, i_rst_n, o_cmd.op == aci_pkg::OP_LOAD, !o_s_tready, "new request taken while one is in work")

endmodule

[hdl/arc_chord_interpolator_unit.sv]
// Top level of the arc chord interpolator: controller plus datapath.
//
//  channel | direction | handshake               | payload
//  s_axis  | in        | tvalid/tready           | tdata 208b, tuser 3b
//  m_axis  | out       | tvalid/tready, tlast    | tdata 96b, tuser 1b
//  cfg     | in        | wr_en, no wait          | index 2b, data 16b
//
// Arc time is set by the shared CORDIC unit and the bit-serial divider; an arc has
// at most 63 chords. A zero-radius command finishes without chord stepping.
// Reset is synchronous, active low, and needs no clearing pass.
// Input is taken only when the previous arc has issued its last request;
// chord emission holds while the output register is full.
module arc_chord_interpolator_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // start_x, start_y, end_x, end_y, offset_i, offset_j, feed_rate
    input  logic [aci_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    // dir_ccw, has_end_x, has_end_y
    input  logic [aci_pkg::IN_TUSER_W-1:0]      i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // point_x, point_y, step_dly, segment_count
    output logic [aci_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    // status
    output logic [aci_pkg::OUT_TUSER_W-1:0]     o_m_axis_tuser,
    output logic                                o_m_axis_tlast,
    input  logic                                i_cfg_wr_en,
    input  logic [aci_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [aci_pkg::CFG_DATA_W-1:0]      i_cfg_wr_data
);

    aci_pkg::t_cmd w_cmd;
    aci_pkg::t_sts w_sts;

    aci_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    aci_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_s_tdata     (i_s_axis_tdata),
        .i_s_tuser     (i_s_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_m_tvalid    (o_m_axis_tvalid),
        .i_m_tready    (i_m_axis_tready),
        .o_m_tdata     (o_m_axis_tdata),
        .o_m_tuser     (o_m_axis_tuser),
        .o_m_tlast     (o_m_axis_tlast)
    );

endmodule

[dv/tb_arc_chord_interpolator_unit.sv]
// Self-checking testbench of the arc chord interpolator: directed and random arcs.
`timescale 1ns / 1ps

module tb_arc_chord_interpolator_unit;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam bit STATUS_MOVE = 1'b0;
    localparam bit STATUS_ZERO_RADIUS = 1'b1;

    typedef struct packed {
        logic        dir_ccw;
        logic [31:0] start_x;
        logic [31:0] start_y;
        logic [31:0] end_x;
        logic [31:0] end_y;
        logic        has_end_x;
        logic        has_end_y;
        logic [31:0] offset_i;
        logic [31:0] offset_j;
        logic [15:0] feed_rate;
    } t_arc_cmd;

    typedef struct packed {
        logic [31:0] point_x;
        logic [31:0] point_y;
        logic [25:0] step_dly;
        logic [5:0]  segment_count;
        logic        status;
        logic        is_last;
    } t_chord_pt;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_s_axis_tvalid = 1'b0;
    logic                             o_s_axis_tready;
    logic [aci_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata = '0;
    logic [aci_pkg::IN_TUSER_W-1:0]   i_s_axis_tuser = '0;
    logic                             o_m_axis_tvalid;
    logic                             i_m_axis_tready = 1'b0;
    logic [aci_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata;
    logic [aci_pkg::OUT_TUSER_W-1:0]  o_m_axis_tuser;
    logic                             o_m_axis_tlast;
    logic                             i_cfg_wr_en = 1'b0;
    logic [aci_pkg::CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [aci_pkg::CFG_DATA_W-1:0]   i_cfg_wr_data = '0;

    arc_chord_interpolator_unit u_dut (.*);

    always #5 i_clk = ~i_clk;

    logic [6:0]  chord_deg;
    logic [13:0] steps_mm;
    logic [15:0] default_delay;
    logic [9:0]  pulse_high;

    t_chord_pt   pending_pts[$];
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_request = 0;
    int          hold_left = 0;
    int          quiet_cycles = 0;

    logic [31:0] atan_steps [32] = '{
        536870912, 316933405, 167458907, 85004756, 42667331, 21354465,
        10680862, 5340245, 2670163, 1335086, 667544, 333772, 166886,
        83443, 41721, 20860, 10430, 5215, 2607, 1303, 651, 325, 162,
        81, 40, 20, 10, 5, 2, 1, 0, 0};

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res = 0;
        logic [63:0] b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] vector_angle(longint x, longint y);
        logic [31:0] ang = 0;
        longint dx, dy;
        if (x == 0 && y == 0) return 32'd0;
        if (x < 0) begin
            x = -x;
            y = -y;
            ang = aci_pkg::HALF_TURN;
        end
        for (int k = 0; k < aci_pkg::CORDIC_ITERS; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (y > 0) begin
                x += dx; y -= dy; ang += atan_steps[k];
            end else begin
                x -= dx; y += dy; ang -= atan_steps[k];
            end
        end
        return ang;
    endfunction

    function automatic void rotate_radius(logic [63:0] r, logic [31:0] a,
                                          output longint ox, output longint oy);
        logic [63:0] prod;
        longint x, y, z, dx, dy;
        prod = r * {32'd0, aci_pkg::CORDIC_KINV};
        x = longint'(prod >> 32);
        y = 0;
        if (((a + aci_pkg::QUARTER_TURN) & aci_pkg::HALF_TURN) != 0) begin
            x = -x;
            a = a - aci_pkg::HALF_TURN;
        end
        z = longint'($signed(a));
        for (int k = 0; k < aci_pkg::CORDIC_ITERS; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(atan_steps[k]);
            end else begin
                x += dx; y -= dy; z += longint'(atan_steps[k]);
            end
        end
        ox = x;
        oy = y;
    endfunction

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    task automatic predict_chords(t_arc_cmd c);
        longint sx, sy, ex, ey, oi, oj, cx, cy, rx, ry;
        logic [63:0] sq, r, dly, mag, deg, segs, spm;
        logic [31:0] as, ae, d, a;
        t_chord_pt p;
        sx = longint'($signed(c.start_x));
        sy = longint'($signed(c.start_y));
        ex = c.has_end_x ? longint'($signed(c.end_x)) : sx;
        ey = c.has_end_y ? longint'($signed(c.end_y)) : sy;
        oi = longint'($signed(c.offset_i));
        oj = longint'($signed(c.offset_j));
        cx = sx + oi;
        cy = sy + oj;
        sq = 64'(oi * oi) + 64'(oj * oj);
        if (sq < (64'd1 << 40) &&
            sq * 64'd1000000 < (64'd1 << (2 * aci_pkg::COORD_FRAC_BITS))) begin
            pending_pts.push_back('{c.start_x, c.start_y, 26'd0, 6'd0,
                                   STATUS_ZERO_RADIUS, 1'b1});
            return;
        end
        r = int_sqrt(sq);
        if (c.feed_rate == 0) begin
            dly = default_delay;
        end else begin
            spm = steps_mm ? steps_mm : 1;
            dly = 64'd60000000 / (c.feed_rate * spm);
            if (dly < pulse_high + 64'd50) dly = pulse_high + 64'd50;
        end
        as = vector_angle(sx - cx, sy - cy);
        ae = vector_angle(ex - cx, ey - cy);
        mag = c.dir_ccw ? {32'd0, ae - as} : {32'd0, as - ae};
        if (mag < aci_pkg::NEAR_ZERO_SWEEP) mag = 64'd1 << 32;
        deg = chord_deg ? chord_deg : 1;
        segs = (mag * 360) / (deg << 32);
        if (segs < 1) segs = 1;
        if (segs > aci_pkg::MAX_SEGMENTS) segs = aci_pkg::MAX_SEGMENTS;
        for (int k = 1; k <= segs; k++) begin
            d = 32'((mag * k) / segs);
            a = c.dir_ccw ? as + d : as - d;
            rotate_radius(r, a, rx, ry);
            p = '{clamp32(cx + rx), clamp32(cy + ry), dly[25:0], segs[5:0],
                  STATUS_MOVE, 1'b0};
            pending_pts.push_back(p);
        end
        pending_pts.push_back('{ex[31:0], ey[31:0], dly[25:0], segs[5:0],
                               STATUS_MOVE, 1'b1});
    endtask

    task automatic send_arc(t_arc_cmd c);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {c.feed_rate, c.offset_j, c.offset_i, c.end_y, c.end_x,
                            c.start_y, c.start_x};
        i_s_axis_tuser  <= {c.has_end_y, c.has_end_x, c.dir_ccw};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_chords(c);
    endtask

    task automatic drain_outputs();
        @(posedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pending_pts.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(aci_pkg::t_cfg_idx idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_index   <= idx;
        i_cfg_wr_data <= val;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        case (idx)
            aci_pkg::CFG_ARC_STEP:   chord_deg     = val[6:0];
            aci_pkg::CFG_STEPS_MM:   steps_mm      = val[13:0];
            aci_pkg::CFG_DEF_DELAY:  default_delay = val;
            aci_pkg::CFG_PULSE_HIGH: pulse_high    = val[9:0];
            default: begin
            end
        endcase
    endtask

    task automatic set_regs(logic [15:0] st, logic [15:0] spm, logic [15:0] dd,
                            logic [15:0] ph);
        drain_outputs();
        write_reg(aci_pkg::CFG_ARC_STEP, st);
        write_reg(aci_pkg::CFG_STEPS_MM, spm);
        write_reg(aci_pkg::CFG_DEF_DELAY, dd);
        write_reg(aci_pkg::CFG_PULSE_HIGH, ph);
    endtask

    function automatic logic [31:0] rand_span();
        int bits;
        bits = $urandom_range(31, 8);
        return ($urandom() & ((32'd1 << bits) - 1)) - (32'd1 << (bits - 1));
    endfunction

    function automatic t_arc_cmd random_arc();
        t_arc_cmd c;
        c = '{1'($urandom_range(1)), $urandom(), $urandom(), $urandom(), $urandom(),
              1'($urandom_range(1)), 1'($urandom_range(1)), $urandom(), $urandom(),
              16'($urandom_range(65535))};
        if ($urandom_range(99) < 80) begin
            // well-formed arc: moderate offsets and an end near the circle
            c.offset_i = rand_span();
            c.offset_j = rand_span();
            c.start_x  = rand_span();
            c.start_y  = rand_span();
            c.end_x    = c.start_x + c.offset_i + rand_span();
            c.end_y    = c.start_y + c.offset_j + rand_span();
            c.has_end_x = $urandom_range(99) < 85;
            c.has_end_y = $urandom_range(99) < 85;
            case ($urandom_range(3))
                0: c.feed_rate = '0;
                1: c.feed_rate = 16'($urandom_range(50));
                default: c.feed_rate = 16'($urandom_range(3000));
            endcase
            if ($urandom_range(99) < 5) c.offset_i = $urandom_range(80) - 40;
            if ($urandom_range(99) < 5) c.offset_j = $urandom_range(80) - 40;
        end
        return c;
    endfunction

    task automatic test_directed();
        t_arc_cmd c;
        c = '{1'b1, 32'h0001_0000, 0, 32'h0001_0000, 0, 1'b1, 1'b1, 65, 0, 16'd100};
        send_arc(c);                                // zero radius, just below limit
        c.offset_i = 66;
        send_arc(c);                                // just above limit
        c.offset_i = 0;
        send_arc(c);                                // zero offsets
        c = '{1'b0, 0, 0, 0, 0, 1'b0, 1'b0, 32'hFFFF_0000, 0, 16'd0};
        send_arc(c);                                // full circle clockwise
        c.dir_ccw = 1'b1;
        send_arc(c);                                // full circle counter-clockwise
        c = '{1'b1, 0, 0, 32'h0001_0000, 0, 1'b1, 1'b1, 32'h0001_0000, 0, 16'd65535};
        send_arc(c);                                // end at the centre
        c = '{1'b1, 32'h0002_0000, 0, 0, 32'h0002_0000, 1'b1, 1'b1, 32'hFFFE_0000, 0, 16'd1};
        send_arc(c);                                // quarter turn ccw
        c.dir_ccw = 1'b0;
        send_arc(c);                                // three quarters cw
        c = '{1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
              1'b1, 1'b1, 32'h8000_0000, 32'h8000_0000, 16'd1};
        send_arc(c);                                // extreme coordinates, saturation
        c = '{1'b0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              1'b1, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd65535};
        send_arc(c);
        c = '{1'b1, 0, 0, 0, 32'h0000_0001, 1'b0, 1'b1, 0, 32'h0010_0000, 16'd60};
        send_arc(c);                                // tiny sweep
        c = '{1'b0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1,
              32'h0000_FFFF, 32'hFFFF_0001, 16'd7};
        send_arc(c);
    endtask

    task automatic test_random_phase(int items, int s_pct, int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (items) send_arc(random_arc());
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 3000;
        repeat (10) send_arc(random_arc());
    endtask

    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_chord_pt got, want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = '{o_m_axis_tdata[31:0], o_m_axis_tdata[63:32], o_m_axis_tdata[89:64],
                    o_m_axis_tdata[95:90], o_m_axis_tuser[0], o_m_axis_tlast};
            if (pending_pts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected point %h", got);
            end else begin
                want = pending_pts.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp x=%h y=%h dly=%0d segs=%0d st=%b last=%b",
                                 want.point_x, want.point_y, want.step_dly,
                                 want.segment_count, want.status, want.is_last,
                                 "  got x=%h y=%h dly=%0d segs=%0d st=%b last=%b",
                                 got.point_x, got.point_y, got.step_dly,
                                 got.segment_count, got.status, got.is_last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
            || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("arc_chord_interpolator_unit verification failed");
            $finish;
        end
    end

    initial begin
        chord_deg     = 7'd6;
        steps_mm      = 14'd200;
        default_delay = 16'd1000;
        pulse_high    = 10'd10;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        set_regs(16'd90, 16'd1, 16'd65535, 16'd1000);
        test_directed();
        set_regs(16'd0, 16'd10000, 16'd1, 16'd1);
        test_random_phase(10, 32, 88);
        set_regs(16'd45, 16'd0, 16'hFFFF, 16'hFFFF);
        test_random_phase(60, 32, 88);
        set_regs(16'd90, 16'd16383, 16'd1000, 16'd10);
        test_random_phase(60, 88, 32);
        set_regs(16'd30, 16'd200, 16'd500, 16'd50);
        test_random_phase(50, 0, 0);
        test_backpressure();
        drain_outputs();
        if (mismatches == 0)
            $display("arc_chord_interpolator_unit verification clean");
        else
            $display("arc_chord_interpolator_unit verification failed");
        $finish;
    end

endmodule
